### sv/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared item types, operation and status codes, and cell commands.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_INS_MID    = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_POP_BACK   = 3'd4;
    localparam logic [2:0] MODE_REM_MID    = 3'd5;
    localparam logic [2:0] MODE_DISPLAY    = 3'd6;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        word_t      value_in;
    } in_item_t;

    typedef struct packed {
        word_t      value_out;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // What a cell loads on the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DISP = 2'b10
    } state_t;

endpackage

### sv/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque storage cell
// Holds one element and takes a new one from either neighbour or the load bus.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                aclk,
    input  bdq_pkg::cell_cmd_t  cmd,
    input  bdq_pkg::word_t      left_val,
    input  bdq_pkg::word_t      right_val,
    input  bdq_pkg::word_t      load_val,
    output bdq_pkg::word_t      val
);
    import bdq_pkg::*;

    word_t val_reg;
    word_t val_next;

    always_comb begin
        unique case (cmd)
            CELL_HOLD:       val_next = val_reg;
            CELL_FROM_LEFT:  val_next = left_val;
            CELL_FROM_RIGHT: val_next = right_val;
            CELL_LOAD:       val_next = load_val;
            default:         val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

### sv/bounded_deque_with_middle_ops_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with middle operations
// Ordered store of signed 32-bit values in a row of shifting cells.
// ----------------------------------------------------------------------------
// Inserts and removals at the front, back or middle (position count/2)
// shift every cell from that position on towards or away from its neighbour
// (none move on a full insert or an empty removal) and write one result item
// to the output register. A display of n elements holds the input closed
// until it ends: the cycle that accepts it emits nothing, then one item
// follows per cycle while the output register is free or being emptied, as
// the chain rotates by one cell per cycle and the front cell is read out;
// after n steps the order is as before. A display of an empty store gives a
// single empty-status item. A new item is accepted whenever the block is not
// displaying and the output register is free or being emptied.
// ----------------------------------------------------------------------------
module bounded_deque_with_middle_ops_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bdq_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bdq_pkg::out_item_t  m_item
);
    import bdq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] disp_cnt_reg, disp_cnt_next;
    out_item_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    word_t            cell_val [CAPACITY];
    cell_cmd_t        cell_cmd [CAPACITY];
    word_t            load_val;

    logic             out_free;
    logic             accept;
    logic             rotating;
    logic             is_ins, is_rem;
    logic             full, empty;
    logic [CNT_W-1:0] ins_pos, rem_pos;
    logic             disp_last;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign rotating = (state_reg == ST_DISP) && out_free;
    assign full     = (count_reg == CAP_CNT);
    assign empty    = (count_reg == '0);
    assign disp_last = ((disp_cnt_reg + CNT_W'(1)) == count_reg);

    always_comb begin
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        ins_pos = '0;
        rem_pos = '0;
        unique case (s_item.mode)
            MODE_PUSH_FRONT: is_ins = 1'b1;
            MODE_PUSH_BACK: begin
                is_ins  = 1'b1;
                ins_pos = count_reg;
            end
            MODE_INS_MID: begin
                is_ins  = 1'b1;
                ins_pos = count_reg >> 1;
            end
            MODE_POP_FRONT: is_rem = 1'b1;
            MODE_POP_BACK: begin
                is_rem  = 1'b1;
                rem_pos = count_reg - CNT_W'(1);
            end
            MODE_REM_MID: begin
                is_rem  = 1'b1;
                rem_pos = count_reg >> 1;
            end
            default: begin
            end
        endcase
    end

    // During display the front element wraps round to the back of the chain.
    assign load_val = rotating ? cell_val[0] : s_item.value_in;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CNT_W-1:0] CI  = CNT_W'(i);
        localparam logic [CNT_W-1:0] CI1 = CNT_W'(i + 1);
        word_t left_val, right_val;

        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_left
            assign left_val = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_lastc
            assign right_val = '0;
        end else begin : g_right
            assign right_val = cell_val[i+1];
        end

        always_comb begin
            cell_cmd[i] = CELL_HOLD;
            if (accept && is_ins && !full) begin
                if (CI == ins_pos) begin
                    cell_cmd[i] = CELL_LOAD;
                end else if (CI > ins_pos && CI <= count_reg) begin
                    cell_cmd[i] = CELL_FROM_LEFT;
                end
            end else if (accept && is_rem && !empty) begin
                if (CI >= rem_pos && CI1 < count_reg) begin
                    cell_cmd[i] = CELL_FROM_RIGHT;
                end
            end else if (rotating) begin
                if (CI1 < count_reg) begin
                    cell_cmd[i] = CELL_FROM_RIGHT;
                end else if (CI1 == count_reg) begin
                    cell_cmd[i] = CELL_LOAD;
                end
            end
        end

        bdq_cell u_cell (
            .aclk      (aclk),
            .cmd       (cell_cmd[i]),
            .left_val  (left_val),
            .right_val (right_val),
            .load_val  (load_val),
            .val       (cell_val[i])
        );
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        disp_cnt_next  = disp_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (accept) begin
            if (is_ins) begin
                out_valid_next    = 1'b1;
                out_next.value_out = '0;
                out_next.last     = 1'b1;
                if (full) begin
                    out_next.status = STAT_FULL;
                end else begin
                    out_next.status = STAT_OK;
                    count_next      = count_reg + CNT_W'(1);
                end
            end else if (is_rem) begin
                out_valid_next = 1'b1;
                out_next.last  = 1'b1;
                if (empty) begin
                    out_next.value_out = '0;
                    out_next.status    = STAT_EMPTY;
                end else begin
                    out_next.value_out = cell_val[rem_pos[IDX_W-1:0]];
                    out_next.status    = STAT_OK;
                    count_next         = count_reg - CNT_W'(1);
                end
            end else if (s_item.mode == MODE_DISPLAY) begin
                if (empty) begin
                    out_valid_next     = 1'b1;
                    out_next.value_out = '0;
                    out_next.status    = STAT_EMPTY;
                    out_next.last      = 1'b1;
                end else begin
                    state_next    = ST_DISP;
                    disp_cnt_next = '0;
                end
            end
        end else if (rotating) begin
            out_valid_next     = 1'b1;
            out_next.value_out = cell_val[0];
            out_next.status    = STAT_OK;
            out_next.last      = disp_last;
            disp_cnt_next      = disp_cnt_reg + CNT_W'(1);
            if (disp_last) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            disp_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            disp_cnt_reg  <= disp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with middle operations - testbench
// Drives a directed table and then random operation bursts through the
// valid/ready input channel, with random idle gaps on the sender and random
// stalls on the receiver. A deque model in this file or a directed row
// gives each expected item, and every block item is compared in arrival order.
// ----------------------------------------------------------------------------
module tb;
    import bdq_pkg::*;

    localparam int unsigned CAPACITY     = 16;
    localparam int unsigned N_RANDOM_OPS = 270;
    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned REPORT_MAX   = 10;

    // Mode 7 has no operation behind it; the block drops such items silently.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam word_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam word_t VAL_MIN = 32'sh8000_0000;

    localparam out_item_t RES_EMPTY = '{value_out: '0, status: STAT_EMPTY, last: 1'b1};
    localparam out_item_t RES_FULL  = '{value_out: '0, status: STAT_FULL, last: 1'b1};
    localparam out_item_t RES_DONE  = '{value_out: '0, status: STAT_OK, last: 1'b1};

    typedef enum logic [1:0] {
        CHK_MODEL  = 2'd0,
        CHK_TYPED  = 2'd1,
        CHK_SILENT = 2'd2
    } check_kind_e;

    typedef struct packed {
        logic [2:0]  mode;
        word_t       value;
        logic [4:0]  reps;
        check_kind_e chk;
        out_item_t   typed;
    } plan_row_t;

    localparam int unsigned N_PLAN = 18;

    // Directed sequence: empty store, single element, extremes, fill to full,
    // refused inserts, full display and removals at each end and the middle.
    plan_row_t dir_plan [N_PLAN] = '{
        '{MODE_POP_FRONT, 32'sd0,           5'd1,  CHK_TYPED,  RES_EMPTY},
        '{MODE_DISPLAY,   32'sd0,           5'd1,  CHK_TYPED,  RES_EMPTY},
        '{MODE_UNUSED,    32'sd7,           5'd1,  CHK_SILENT, RES_DONE},
        '{MODE_PUSH_BACK, 32'sh1234_5678,   5'd1,  CHK_TYPED,  RES_DONE},
        '{MODE_REM_MID,   32'sd0,           5'd1,  CHK_MODEL,  RES_DONE},
        '{MODE_REM_MID,   32'sd0,           5'd1,  CHK_TYPED,  RES_EMPTY},
        '{MODE_PUSH_FRONT, VAL_MAX,         5'd1,  CHK_TYPED,  RES_DONE},
        '{MODE_PUSH_BACK, VAL_MIN,          5'd1,  CHK_TYPED,  RES_DONE},
        '{MODE_INS_MID,   32'sd0,           5'd1,  CHK_TYPED,  RES_DONE},
        '{MODE_INS_MID,   -32'sd1,          5'd1,  CHK_TYPED,  RES_DONE},
        '{MODE_DISPLAY,   32'sd0,           5'd1,  CHK_MODEL,  RES_DONE},
        '{MODE_PUSH_BACK, 32'sh0000_0100,   5'd12, CHK_MODEL,  RES_DONE},
        '{MODE_PUSH_FRONT, 32'sd5,          5'd1,  CHK_TYPED,  RES_FULL},
        '{MODE_INS_MID,   32'sd6,           5'd1,  CHK_TYPED,  RES_FULL},
        '{MODE_DISPLAY,   32'sd0,           5'd1,  CHK_MODEL,  RES_DONE},
        '{MODE_POP_BACK,  32'sd0,           5'd1,  CHK_MODEL,  RES_DONE},
        '{MODE_REM_MID,   32'sd0,           5'd1,  CHK_MODEL,  RES_DONE},
        '{MODE_POP_FRONT, 32'sd0,           5'd1,  CHK_MODEL,  RES_DONE}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    word_t     deque_cells[$];
    out_item_t expected_results[$];

    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned ops_accepted = 0;
    int unsigned displays_run = 0;
    int unsigned full_refusals = 0;
    int unsigned empty_hits = 0;
    int unsigned idle_cycles = 0;

    bounded_deque_with_middle_ops_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic out_item_t insert_at(input int unsigned pos, input word_t v);
        if (deque_cells.size() >= CAPACITY) begin
            return RES_FULL;
        end
        if (pos >= deque_cells.size()) begin
            deque_cells.insert(deque_cells.size(), v);
        end else begin
            deque_cells.insert(pos, v);
        end
        return RES_DONE;
    endfunction

    function automatic out_item_t remove_at(input int unsigned pos);
        out_item_t res;
        if (deque_cells.size() == 0) begin
            return RES_EMPTY;
        end
        res = RES_DONE;
        res.value_out = deque_cells[pos];
        deque_cells.delete(pos);
        return res;
    endfunction

    // Applies one operation to the local copy of the store and returns the
    // result items it should cause, in order.
    task automatic predict_op(input in_item_t op, output out_item_t res[$]);
        int unsigned n;
        out_item_t   one;
        n = deque_cells.size();
        res = {};
        case (op.mode)
            MODE_PUSH_FRONT: res = {insert_at(0, op.value_in)};
            MODE_PUSH_BACK:  res = {insert_at(n, op.value_in)};
            MODE_INS_MID:    res = {insert_at(n / 2, op.value_in)};
            MODE_POP_FRONT:  res = {remove_at(0)};
            MODE_POP_BACK:   res = {remove_at((n == 0) ? 0 : n - 1)};
            MODE_REM_MID:    res = {remove_at(n / 2)};
            MODE_DISPLAY: begin
                if (n == 0) begin
                    res = {RES_EMPTY};
                end else begin
                    for (int unsigned i = 0; i < n; i++) begin
                        one = '{value_out: deque_cells[i], status: STAT_OK,
                                last: (i + 1 == n)};
                        res = {res, one};
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Presents one item after an optional idle gap, waits for it to be taken,
    // then records what the block should return for it.
    task automatic send_op(input in_item_t op, input check_kind_e chk,
                           input out_item_t typed, input int unsigned gap);
        out_item_t res[$];
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= op;
        do @(posedge aclk); while (!s_ready);
        predict_op(op, res);
        if (op.mode != MODE_UNUSED) begin
            ops_accepted++;
        end
        if (op.mode == MODE_DISPLAY) begin
            displays_run++;
        end
        foreach (res[i]) begin
            if (res[i].status == STAT_FULL) full_refusals++;
            if (res[i].status == STAT_EMPTY) empty_hits++;
        end
        case (chk)
            CHK_TYPED:  expected_results = {expected_results, typed};
            CHK_SILENT: ;
            default: begin
                foreach (res[i]) expected_results = {expected_results, res[i]};
            end
        endcase
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected result item: value %0d status %0d last %0b",
                    m_item.value_out, m_item.status, m_item.last));
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                results_checked++;
                if (m_item.value_out !== want.value_out || m_item.status !== want.status
                        || m_item.last !== want.last) begin
                    note_mismatch($sformatf({
                        "result item differs: expected value %0d status %0d last %0b, ",
                        "got value %0d status %0d last %0b"},
                        want.value_out, want.status, want.last,
                        m_item.value_out, m_item.status, m_item.last));
                end
            end
        end
    end

    // The receiver alternates runs of readiness with stalls of random length.
    initial begin : sink_pacing
        int unsigned run_len;
        int unsigned stall_len;
        @(posedge aclk);
        forever begin
            run_len = $urandom_range(1, 60);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        in_item_t    op;
        int unsigned random_ops;
        int unsigned burst_len;
        int unsigned insert_pct;
        int unsigned r;
        bit          quiet;
        word_t       corner_vals[4];

        corner_vals = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1};
        random_ops = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_plan[row]) begin
            for (int unsigned k = 0; k < dir_plan[row].reps; k++) begin
                op.mode     = dir_plan[row].mode;
                op.value_in = dir_plan[row].value + word_t'(k);
                send_op(op, dir_plan[row].chk, dir_plan[row].typed, pick_gap());
            end
        end

        // Bursts lean towards filling, draining or neither, so the store
        // keeps swinging between empty and full.
        while (random_ops < N_RANDOM_OPS) begin
            burst_len = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
                0:       insert_pct = 20;
                1:       insert_pct = 50;
                default: insert_pct = 85;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    op.mode = MODE_UNUSED;
                end else if (r < 12) begin
                    op.mode = MODE_DISPLAY;
                end else if ($urandom_range(0, 99) < insert_pct) begin
                    case ($urandom_range(0, 2))
                        0:       op.mode = MODE_PUSH_FRONT;
                        1:       op.mode = MODE_PUSH_BACK;
                        default: op.mode = MODE_INS_MID;
                    endcase
                end else begin
                    case ($urandom_range(0, 2))
                        0:       op.mode = MODE_POP_FRONT;
                        1:       op.mode = MODE_POP_BACK;
                        default: op.mode = MODE_REM_MID;
                    endcase
                end
                if ($urandom_range(0, 7) == 0) begin
                    op.value_in = corner_vals[$urandom_range(0, 3)];
                end else begin
                    op.value_in = word_t'($urandom);
                end
                send_op(op, CHK_MODEL, RES_DONE, quiet ? 0 : pick_gap());
                if (op.mode != MODE_UNUSED) begin
                    random_ops++;
                end
            end
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0) begin
            note_mismatch($sformatf("%0d expected result items never arrived",
                                    expected_results.size()));
        end
        $display("Ran %0d operations, %0d of them displays; checked %0d result items.",
                 ops_accepted, displays_run, results_checked);
        $display("Inserts refused on a full store: %0d; operations on an empty store: %0d.",
                 full_refusals, empty_hits);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
